FILE: sv/ssff_pkg.sv
// shared types, command codes and segment table for the frame formatter
package ssff_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTRW = $clog2(QDEPTH);
	localparam int unsigned QCNTW = $clog2(QDEPTH + 1);

	localparam logic [2:0] CMD_HEX = 3'd0;
	localparam logic [2:0] CMD_DEC = 3'd1;
	localparam logic [2:0] CMD_RAW = 3'd2;
	localparam logic [2:0] CMD_INT = 3'd3;
	localparam logic [2:0] CMD_INIT = 3'd4;

	localparam logic [15:0] FR_TEST_OFF = 16'h0F00;
	localparam logic [15:0] FR_SCAN = 16'h0B00;
	localparam logic [15:0] FR_DECODE_OFF = 16'h0900;
	localparam logic [15:0] FR_WAKE = 16'h0C01;
	localparam logic [15:0] FR_INT_MAX = 16'h0AFF;
	localparam logic [15:0] FR_INT = 16'h0A00;

	localparam logic [15:0] DEC_LIMIT = 16'd9999;
	// floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
	localparam logic [15:0] DIV10_MUL = 16'hCCCD;
	localparam int unsigned DIV10_SHIFT = 19;

	localparam logic [3:0] STEP_LAST_DIGITS = 4'd3;
	localparam logic [3:0] STEP_LAST_INT = 4'd0;
	localparam logic [3:0] STEP_LAST_INIT = 4'd8;
	localparam logic [3:0] STEP_INIT_HEX = 4'd5;

	typedef enum logic [4:0] {
		OP_HEX = 5'b00001,
		OP_DEC = 5'b00010,
		OP_RAW = 5'b00100,
		OP_INT = 5'b01000,
		OP_INIT = 5'b10000
	} op_t;

	typedef struct packed {
		op_t op;
		logic [15:0] value;
		logic [31:0] raw_pattern;
		logic [7:0] level;
		logic over;
	} entry_t;

	function automatic logic [7:0] seg_pattern(input logic [3:0] nib);
		logic [7:0] p;
		case (nib)
			4'h0: p = 8'h7E;
			4'h1: p = 8'h30;
			4'h2: p = 8'h6D;
			4'h3: p = 8'h79;
			4'h4: p = 8'h33;
			4'h5: p = 8'h5B;
			4'h6: p = 8'h5F;
			4'h7: p = 8'h70;
			4'h8: p = 8'h7F;
			4'h9: p = 8'h7B;
			4'hA: p = 8'h77;
			4'hB: p = 8'h1F;
			4'hC: p = 8'h4E;
			4'hD: p = 8'h3D;
			4'hE: p = 8'h4F;
			default: p = 8'h47;
		endcase
		return p;
	endfunction

endpackage

FILE: sv/ssff_front.sv
// front end: classifies each accepted command into a queue entry
module ssff_front (
	input logic push,
	input logic full,
	input logic [2:0] cmd,
	input logic [15:0] value,
	input logic [31:0] raw_pattern,
	input logic [7:0] level,
	output logic wr_en,
	output ssff_pkg::entry_t wr_entry
);

	logic known;

	always_comb begin
		known = 1'b1;
		wr_entry.op = ssff_pkg::OP_HEX;
		wr_entry.value = value;
		wr_entry.raw_pattern = raw_pattern;
		wr_entry.level = level;
		wr_entry.over = 1'b0;
		unique case (cmd)
			ssff_pkg::CMD_HEX: wr_entry.op = ssff_pkg::OP_HEX;
			ssff_pkg::CMD_DEC: begin
				wr_entry.op = ssff_pkg::OP_DEC;
				wr_entry.over = (value > ssff_pkg::DEC_LIMIT);
			end
			ssff_pkg::CMD_RAW: wr_entry.op = ssff_pkg::OP_RAW;
			ssff_pkg::CMD_INT: wr_entry.op = ssff_pkg::OP_INT;
			ssff_pkg::CMD_INIT: begin
				wr_entry.op = ssff_pkg::OP_INIT;
				// init ends with a hex view of zero
				wr_entry.value = '0;
			end
			default: known = 1'b0;
		endcase
	end

	// unknown commands are taken and dropped
	assign wr_en = push && !full && known;

endmodule

FILE: sv/ssff_queue.sv
// short queue of classified commands between front and back
module ssff_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input ssff_pkg::entry_t wr_entry,
	output logic full,
	input logic rd_en,
	output logic rd_valid,
	output ssff_pkg::entry_t rd_entry
);

	ssff_pkg::entry_t mem_q [ssff_pkg::QDEPTH];
	logic [ssff_pkg::QPTRW-1:0] wr_ptr_q;
	logic [ssff_pkg::QPTRW-1:0] rd_ptr_q;
	logic [ssff_pkg::QCNTW-1:0] count_q;
	logic do_rd;

	assign full = (count_q == ssff_pkg::QCNTW'(ssff_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == ssff_pkg::QPTRW'(ssff_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == ssff_pkg::QPTRW'(ssff_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && do_rd) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/ssff_back.sv
// back end: steps through the frames of one command into an output register
module ssff_back (
	input logic clk,
	input logic arst_n,
	input logic [2:0] scan_limit,
	input logic rd_valid,
	input ssff_pkg::entry_t rd_entry,
	output logic rd_en,
	output logic empty,
	input logic pop,
	output logic [15:0] frame_word,
	output logic last_of_run,
	output logic over_range
);

	logic busy_q;
	ssff_pkg::op_t op_q;
	logic [3:0] step_q;
	logic [15:0] val_q;
	logic [31:0] raw_q;
	logic [7:0] level_q;
	logic over_q;

	logic out_valid_q;
	logic [15:0] frame_q;
	logic last_q;
	logic ovr_q;

	logic advance;
	logic is_last;
	logic [3:0] last_step;
	logic [3:0] digit_idx;
	logic [31:0] prod;
	logic [15:0] quot;
	logic [15:0] quot_x10;
	logic [3:0] nibble;
	logic [15:0] next_val;
	logic [15:0] frame_d;

	assign advance = busy_q && (!out_valid_q || pop);

	// divide by ten through the reciprocal, one decimal digit per frame
	assign prod = val_q * ssff_pkg::DIV10_MUL;
	assign quot = 16'(prod >> ssff_pkg::DIV10_SHIFT);
	assign quot_x10 = (quot << 3) + (quot << 1);

	always_comb begin
		last_step = ssff_pkg::STEP_LAST_DIGITS;
		digit_idx = step_q;
		nibble = val_q[3:0];
		next_val = val_q >> 4;
		frame_d = '0;
		unique case (op_q)
			ssff_pkg::OP_HEX: begin
				frame_d = {4'd0, 4'd4 - digit_idx, ssff_pkg::seg_pattern(nibble)};
			end
			ssff_pkg::OP_DEC: begin
				nibble = 4'(val_q - quot_x10);
				next_val = quot;
				frame_d = {4'd0, 4'd4 - digit_idx, ssff_pkg::seg_pattern(nibble)};
			end
			ssff_pkg::OP_RAW: begin
				frame_d = {4'd0, step_q + 4'd1, raw_q[7:0]};
			end
			ssff_pkg::OP_INT: begin
				last_step = ssff_pkg::STEP_LAST_INT;
				frame_d = ssff_pkg::FR_INT | {8'd0, level_q};
			end
			ssff_pkg::OP_INIT: begin
				last_step = ssff_pkg::STEP_LAST_INIT;
				digit_idx = step_q - ssff_pkg::STEP_INIT_HEX;
				case (step_q)
					4'd0: frame_d = ssff_pkg::FR_TEST_OFF;
					4'd1: frame_d = ssff_pkg::FR_SCAN | {13'd0, scan_limit};
					4'd2: frame_d = ssff_pkg::FR_DECODE_OFF;
					4'd3: frame_d = ssff_pkg::FR_WAKE;
					4'd4: frame_d = ssff_pkg::FR_INT_MAX;
					default: frame_d = {4'd0, 4'd4 - digit_idx,
						ssff_pkg::seg_pattern(nibble)};
				endcase
			end
			default: frame_d = '0;
		endcase
	end

	assign is_last = (step_q == last_step);
	assign rd_en = !busy_q || (advance && is_last);

	always_ff @(posedge clk) begin
		if (rd_en && rd_valid) begin
			op_q <= rd_entry.op;
			val_q <= rd_entry.value;
			raw_q <= rd_entry.raw_pattern;
			level_q <= rd_entry.level;
			over_q <= rd_entry.over;
		end else if (advance) begin
			raw_q <= raw_q >> 8;
			// setup frames of init leave the digit value alone
			if (op_q != ssff_pkg::OP_INIT || step_q >= ssff_pkg::STEP_INIT_HEX) begin
				val_q <= next_val;
			end
		end
		if (advance) begin
			frame_q <= frame_d;
			last_q <= is_last;
			ovr_q <= over_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				busy_q <= rd_valid;
				step_q <= '0;
			end else if (advance) begin
				step_q <= step_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign frame_word = frame_q;
	assign last_of_run = last_q;
	assign over_range = ovr_q;

endmodule

FILE: sv/seven_segment_frame_formatter_core.sv
// top level of the seven-segment display frame formatter
//
// channel   direction  handshake          word
// command   in         push / full        cmd, value, raw_pattern, level
// frame     out        pop / empty        frame_word, last_of_run, over_range
// config    in         cfg_we             cfg_wdata -> scan_limit
//
// frames per command: hex, decimal and raw give 4, intensity 1, init 9
// unless stalled, the back end steps one frame per cycle from a two-entry queue,
// so a new command is taken while the previous one is still being sent
// a decimal digit costs one 16x16 reciprocal multiply per frame
// reset empties the queue and output register and sets scan_limit to 4
// a held pop stalls the back end only; the front stalls only when the queue is full
module seven_segment_frame_formatter_core (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] cmd,
	input logic [15:0] value,
	input logic [31:0] raw_pattern,
	input logic [7:0] level,
	output logic empty,
	input logic pop,
	output logic [15:0] frame_word,
	output logic last_of_run,
	output logic over_range,
	input logic cfg_we,
	input logic [2:0] cfg_wdata
);

	logic [2:0] scan_limit_q;
	logic wr_en;
	ssff_pkg::entry_t wr_entry;
	logic rd_en;
	logic rd_valid;
	ssff_pkg::entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= 3'd4;
		end else if (cfg_we) begin
			scan_limit_q <= cfg_wdata;
		end
	end

	ssff_front u_front (
		.push(push),
		.full(full),
		.cmd(cmd),
		.value(value),
		.raw_pattern(raw_pattern),
		.level(level),
		.wr_en(wr_en),
		.wr_entry(wr_entry)
	);

	ssff_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_entry(wr_entry),
		.full(full),
		.rd_en(rd_en),
		.rd_valid(rd_valid),
		.rd_entry(rd_entry)
	);

	ssff_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.scan_limit(scan_limit_q),
		.rd_valid(rd_valid),
		.rd_entry(rd_entry),
		.rd_en(rd_en),
		.empty(empty),
		.pop(pop),
		.frame_word(frame_word),
		.last_of_run(last_of_run),
		.over_range(over_range)
	);

endmodule

FILE: sv/ssff_checker.sv
// port-level checks for the frame formatter, bound to the top level
module ssff_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [15:0] frame_word,
	input logic last_of_run,
	input logic over_range
);

	// a waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(frame_word))
		else $error("waiting word changed or vanished");

	// frames of a run follow without a gap
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_run |=> !empty)
		else $error("gap inside a run of frames");

	// over-range frames are digit frames with no point
	a_over_digit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && over_range |-> frame_word[15:11] == 5'd0 && frame_word[7] == 1'b0)
		else $error("over-range flag on a non-digit frame");

	// the over-range flag is the same across one run
	a_over_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_run |=> over_range == $past(over_range))
		else $error("over-range flag changed inside a run");

endmodule

bind seven_segment_frame_formatter_core ssff_checker u_ssff_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.frame_word(frame_word),
	.last_of_run(last_of_run),
	.over_range(over_range)
);

FILE: sim/tb_top.sv
// self-checking testbench for the seven-segment frame formatter core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] CMD_UNKNOWN_MID = 3'd6;
	localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
	localparam logic [2:0] SCAN_LIMIT_RESET = 3'd4;

	localparam logic [15:0] FRAME_TEST_OFF = 16'h0F00;
	localparam logic [15:0] FRAME_SCAN = 16'h0B00;
	localparam logic [15:0] FRAME_NO_DECODE = 16'h0900;
	localparam logic [15:0] FRAME_WAKE = 16'h0C01;
	localparam logic [15:0] FRAME_FULL_BRIGHT = 16'h0AFF;
	localparam logic [15:0] FRAME_BRIGHT = 16'h0A00;
	// segment glyphs for nibbles f down to 0, nibble 0 in the low byte
	localparam logic [127:0] GLYPHS = {8'h47, 8'h4F, 8'h3D, 8'h4E, 8'h1F, 8'h77, 8'h7B, 8'h7F,
		8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E};

	localparam int RANDOM_PHASES = 5;
	localparam int CMDS_PER_PHASE = 70;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic [2:0] cmd;
		logic [15:0] value;
		logic [31:0] raw;
		logic [7:0] level;
	} display_cmd_t;

	typedef struct {
		logic [15:0] word;
		logic last;
		logic over;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] cmd = ssff_pkg::CMD_HEX;
	logic [15:0] value = '0;
	logic [31:0] raw_pattern = '0;
	logic [7:0] level = '0;
	logic empty;
	logic pop = 1'b0;
	logic [15:0] frame_word;
	logic last_of_run;
	logic over_range;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_wdata = '0;

	display_cmd_t pending_cmds[$];
	frame_t frames_due[$];
	logic [2:0] scan_limit_copy = SCAN_LIMIT_RESET;

	int gap_max = 0;
	int stall_pct = 0;
	int burst_left = 1;
	int gap_left = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int cmds_taken = 0;
	int frames_checked = 0;
	int cmd_seen [8];
	int settings_used = 1;

	seven_segment_frame_formatter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.value(value),
		.raw_pattern(raw_pattern),
		.level(level),
		.empty(empty),
		.pop(pop),
		.frame_word(frame_word),
		.last_of_run(last_of_run),
		.over_range(over_range),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] glyph(input logic [3:0] nib);
		return GLYPHS[{nib, 3'b000} +: 8];
	endfunction

	// expected frame run for one accepted command
	function automatic void predict_frames(input display_cmd_t c);
		logic [15:0] words [9];
		logic [15:0] rem;
		logic [7:0] addr;
		logic ov;
		int n;
		n = 0;
		ov = 1'b0;
		case (c.cmd)
			ssff_pkg::CMD_HEX, ssff_pkg::CMD_INIT: begin
				rem = (c.cmd == ssff_pkg::CMD_HEX) ? c.value : 16'd0;
				if (c.cmd == ssff_pkg::CMD_INIT) begin
					words[0] = FRAME_TEST_OFF;
					words[1] = FRAME_SCAN | {13'd0, scan_limit_copy};
					words[2] = FRAME_NO_DECODE;
					words[3] = FRAME_WAKE;
					words[4] = FRAME_FULL_BRIGHT;
					n = 5;
				end
				for (addr = 8'd4; addr >= 8'd1; addr--) begin
					words[n] = {addr, glyph(rem[3:0])};
					n++;
					rem = rem >> 4;
				end
			end
			ssff_pkg::CMD_DEC: begin
				ov = c.value > 16'd9999;
				rem = c.value % 16'd10000;
				for (addr = 8'd4; addr >= 8'd1; addr--) begin
					words[n] = {addr, glyph(4'(rem % 16'd10))};
					n++;
					rem = rem / 16'd10;
				end
			end
			ssff_pkg::CMD_RAW: begin
				for (addr = 8'd1; addr <= 8'd4; addr++) begin
					words[n] = {addr, c.raw[(addr - 8'd1) * 8 +: 8]};
					n++;
				end
			end
			ssff_pkg::CMD_INT: begin
				words[0] = FRAME_BRIGHT | {8'd0, c.level};
				n = 1;
			end
			default: n = 0;
		endcase
		for (int i = 0; i < n; i++)
			frames_due.push_back('{words[i], i == n - 1, ov});
	endfunction

	function automatic display_cmd_t random_cmd();
		display_cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 22)
			c.cmd = ssff_pkg::CMD_HEX;
		else if (pick < 50)
			c.cmd = ssff_pkg::CMD_DEC;
		else if (pick < 72)
			c.cmd = ssff_pkg::CMD_RAW;
		else if (pick < 86)
			c.cmd = ssff_pkg::CMD_INT;
		else if (pick < 95)
			c.cmd = ssff_pkg::CMD_INIT;
		else
			c.cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
		pick = $urandom_range(0, 9);
		// lean on the decimal range boundary and the extremes now and then
		if (pick == 0)
			c.value = 16'(9994 + $urandom_range(0, 12));
		else if (pick == 1)
			c.value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		else
			c.value = 16'($urandom());
		c.raw = $urandom();
		c.level = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic queue_cmd(input logic [2:0] c, input logic [15:0] v, input logic [31:0] r,
		input logic [7:0] l);
		pending_cmds.push_back('{c, v, r, l});
	endtask

	// wait until every command is taken and every frame is back, then let the core settle
	task automatic drain();
		while (pending_cmds.size() != 0 || push || frames_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scan_limit(input logic [2:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		scan_limit_copy = lim;
		settings_used++;
	endtask

	// command driver: bursts of random length with random gaps
	always @(posedge clk) begin
		display_cmd_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_frames('{cmd, value, raw_pattern, level});
				cmds_taken++;
				cmd_seen[cmd]++;
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					nxt = pending_cmds.pop_front();
					push <= 1'b1;
					cmd <= nxt.cmd;
					value <= nxt.value;
					raw_pattern <= nxt.raw;
					level <= nxt.level;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// frame monitor and receiver stalls
	always @(posedge clk) begin
		frame_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				frames_checked++;
				if (frames_due.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("%0t: unexpected frame word=%h last=%b over=%b", $realtime,
							frame_word, last_of_run, over_range);
				end else begin
					want = frames_due.pop_front();
					if (frame_word !== want.word || last_of_run !== want.last
						|| over_range !== want.over) begin
						errors++;
						if (errors <= MAX_SHOWN)
							$display("%0t: mismatch exp %h/%b/%b got %h/%b/%b",
								$realtime, want.word, want.last, want.over, frame_word,
								last_of_run, over_range);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_asked != hold_served) begin
				hold_served++;
				hold_left = LONG_HOLD;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every nibble, decimal boundaries, byte extremes, init at reset limit
		gap_max = 2;
		stall_pct = 20;
		queue_cmd(ssff_pkg::CMD_HEX, 16'h0000, '0, '0);
		queue_cmd(ssff_pkg::CMD_HEX, 16'hFFFF, '0, '0);
		queue_cmd(ssff_pkg::CMD_HEX, 16'h0123, '0, '0);
		queue_cmd(ssff_pkg::CMD_HEX, 16'h4567, '0, '0);
		queue_cmd(ssff_pkg::CMD_HEX, 16'h89AB, '0, '0);
		queue_cmd(ssff_pkg::CMD_HEX, 16'hCDEF, '0, '0);
		queue_cmd(ssff_pkg::CMD_DEC, 16'd0, '0, '0);
		queue_cmd(ssff_pkg::CMD_DEC, 16'd9999, '0, '0);
		queue_cmd(ssff_pkg::CMD_DEC, 16'd10000, '0, '0);
		queue_cmd(ssff_pkg::CMD_DEC, 16'd65535, '0, '0);
		queue_cmd(ssff_pkg::CMD_DEC, 16'd1234, '0, '0);
		queue_cmd(ssff_pkg::CMD_DEC, 16'd5678, '0, '0);
		queue_cmd(ssff_pkg::CMD_RAW, '0, 32'h0000_0000, '0);
		queue_cmd(ssff_pkg::CMD_RAW, '0, 32'hFFFF_FFFF, '0);
		queue_cmd(ssff_pkg::CMD_RAW, '0, 32'h1234_5678, '0);
		queue_cmd(ssff_pkg::CMD_INT, '0, '0, 8'h00);
		queue_cmd(ssff_pkg::CMD_INT, '0, '0, 8'hFF);
		queue_cmd(ssff_pkg::CMD_INIT, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
		queue_cmd(CMD_UNKNOWN_LO, 16'h1234, 32'hDEAD_BEEF, 8'h5A);
		queue_cmd(CMD_UNKNOWN_MID, '0, '0, '0);
		queue_cmd(CMD_UNKNOWN_HI, 16'hFFFF, '0, 8'hFF);
		queue_cmd(ssff_pkg::CMD_HEX, 16'hA5A5, '0, '0);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin write_scan_limit(3'd7); gap_max = 0; stall_pct = 0; end
				1: begin write_scan_limit(3'd0); gap_max = 0; stall_pct = 30; end
				2: begin write_scan_limit(3'd3); gap_max = 8; stall_pct = 50; end
				3: begin write_scan_limit(3'd5); gap_max = 20; stall_pct = 10; end
				default: begin
					write_scan_limit(3'($urandom_range(0, 7)));
					gap_max = 3;
					stall_pct = 70;
				end
			endcase
			// receiver goes quiet for a long stretch so the core backs up into full
			if (phase == 1)
				hold_asked++;
			for (int i = 0; i < CMDS_PER_PHASE; i++) begin
				pending_cmds.push_back(random_cmd());
				// sender stops half way and waits for every frame to come back
				if (phase == 2 && i == CMDS_PER_PHASE / 2)
					drain();
			end
			drain();
		end

		$display("covered %0d commands: hex %0d, dec %0d, raw %0d, int %0d, init %0d, unknown %0d",
			cmds_taken, cmd_seen[ssff_pkg::CMD_HEX], cmd_seen[ssff_pkg::CMD_DEC],
			cmd_seen[ssff_pkg::CMD_RAW], cmd_seen[ssff_pkg::CMD_INT],
			cmd_seen[ssff_pkg::CMD_INIT],
			cmd_seen[CMD_UNKNOWN_LO] + cmd_seen[CMD_UNKNOWN_MID] + cmd_seen[CMD_UNKNOWN_HI]);
		$display("checked %0d frames over %0d scan limit settings, %0d mismatches",
			frames_checked, settings_used, errors);
		if (errors == 0 && frames_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
